[src/dte_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dte_pkg
// Shared constants, register map and types of the throughput estimator.
// ----------------------------------------------------------------------------
package dte_pkg;

  localparam int unsigned HistoryDepthDef = 24;
  localparam int unsigned ApbAddrW        = 4;
  localparam int unsigned ApbDataW        = 32;

  localparam logic [16:0] OneQ16     = 17'd65536;
  localparam logic [19:0] UsecPerSec = 20'd1000000;
  localparam logic [39:0] RateMax    = 40'hFF_FFFF_FFFF;
  localparam logic [47:0] PredMax    = 48'hFFFF_FFFF_FFFF;

  localparam logic [16:0] AlphaFastRst   = 17'd32768;
  localparam logic [16:0] AlphaSlowRst   = 17'd6554;
  localparam logic [4:0]  WindowLenRst   = 5'd8;
  localparam logic [16:0] BlendWeightRst = 17'd39322;

  typedef enum logic [1:0] {
    REG_ALPHA_FAST   = 2'd0,
    REG_ALPHA_SLOW   = 2'd1,
    REG_WINDOW_LEN   = 2'd2,
    REG_BLEND_WEIGHT = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [16:0] fast_weight;
    logic [16:0] slow_weight;
    logic [4:0]  window_len;
    logic [16:0] blend_weight;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

[src/dte_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dte_req_if / dte_rsp_if
// Valid/ready channels carrying request and result words.
// ----------------------------------------------------------------------------
interface dte_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] total_time_us;
  logic [31:0] first_byte_us;
  logic [31:0] download_bytes;
  logic [31:0] segment_bytes;

  modport source (output valid, req_type, total_time_us, first_byte_us, download_bytes,
                  segment_bytes, input ready);
  modport sink (input valid, req_type, total_time_us, first_byte_us, download_bytes,
                segment_bytes, output ready);
endinterface

interface dte_rsp_if;
  logic        valid;
  logic        ready;
  logic [39:0] throughput_bps;
  logic [31:0] median_ttfb_us;
  logic [47:0] predicted_us;
  logic [4:0]  history_count;

  modport source (output valid, throughput_bps, median_ttfb_us, predicted_us, history_count,
                  input ready);
  modport sink (input valid, throughput_bps, median_ttfb_us, predicted_us, history_count,
                output ready);
endinterface

[src/dte_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dte_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module dte_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 24,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/dte_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dte_div
// 64 by 64 bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dte_div
  import dte_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [63:0] dvs_q, dvs_d;
  logic [64:0] shifted;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    shifted = {rem_q[63:0], quo_q[63]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = shifted - {1'b0, dvs_q};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[src/dte_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dte_regs
// APB configuration registers: EWMA weights, window length, blend weight.
// ----------------------------------------------------------------------------
module dte_regs
  import dte_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_ALPHA_FAST:   cfg_d.fast_weight  = pwdata[16:0];
        REG_ALPHA_SLOW:   cfg_d.slow_weight  = pwdata[16:0];
        REG_WINDOW_LEN:   cfg_d.window_len   = pwdata[4:0];
        REG_BLEND_WEIGHT: cfg_d.blend_weight = pwdata[16:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ALPHA_FAST:   prdata = ApbDataW'(cfg_q.fast_weight);
      REG_ALPHA_SLOW:   prdata = ApbDataW'(cfg_q.slow_weight);
      REG_WINDOW_LEN:   prdata = ApbDataW'(cfg_q.window_len);
      REG_BLEND_WEIGHT: prdata = ApbDataW'(cfg_q.blend_weight);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_weight  <= AlphaFastRst;
      cfg_q.slow_weight  <= AlphaSlowRst;
      cfg_q.window_len   <= WindowLenRst;
      cfg_q.blend_weight <= BlendWeightRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/download_throughput_estimator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// download_throughput_estimator
// Bandwidth estimator: EWMAs, harmonic mean and median first-byte time.
// ----------------------------------------------------------------------------
// A record word pushes the download's payload rate and first-byte time into two
// history RAMs, updates the fast and slow EWMAs, then recomputes the median
// first-byte time (rank count over the ring) and the harmonic mean over the
// newest window entries; its result carries the blended throughput. A predict
// word returns median plus segment transfer time at the blended throughput.
// One word is in work at a time; the next word is taken while a result waits
// in the output register. All divisions share one serial divider, and the
// median scan reads the first-byte RAM once per cycle.
// ----------------------------------------------------------------------------
module download_throughput_estimator
  import dte_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HistoryDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  dte_req_if.sink             req_i,
  dte_rsp_if.source           rsp_o
);

  localparam int unsigned IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned WIN_W = (CNT_W > 5) ? CNT_W : 5;
  localparam int unsigned SB_W  = CNT_W + 1;

  typedef enum logic [28:0] {
    S_IDLE  = 29'd1 << 0,
    S_RMUL  = 29'd1 << 1,
    S_RDIV  = 29'd1 << 2,
    S_RDW   = 29'd1 << 3,
    S_EF    = 29'd1 << 4,
    S_ES    = 29'd1 << 5,
    S_M1    = 29'd1 << 6,
    S_M2    = 29'd1 << 7,
    S_M3    = 29'd1 << 8,
    S_M4    = 29'd1 << 9,
    S_MDI   = 29'd1 << 10,
    S_MRD   = 29'd1 << 11,
    S_MCAP  = 29'd1 << 12,
    S_MSCAN = 29'd1 << 13,
    S_MEVAL = 29'd1 << 14,
    S_MFIN  = 29'd1 << 15,
    S_HINI  = 29'd1 << 16,
    S_HRD   = 29'd1 << 17,
    S_HCHK  = 29'd1 << 18,
    S_HDW   = 29'd1 << 19,
    S_HNXT  = 29'd1 << 20,
    S_HFIN  = 29'd1 << 21,
    S_HFW   = 29'd1 << 22,
    S_BSET  = 29'd1 << 23,
    S_FIN   = 29'd1 << 24,
    S_PMUL  = 29'd1 << 25,
    S_PDIV  = 29'd1 << 26,
    S_PDW   = 29'd1 << 27,
    S_OUT   = 29'd1 << 28
  } state_e;

  typedef enum logic [1:0] {
    MIX_FAST  = 2'd0,
    MIX_SLOW  = 2'd1,
    MIX_BLEND = 2'd2
  } mix_sel_e;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // control state
  state_e           state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovalid_q, ovalid_d;
  logic [55:0]      ef_q, ef_d;
  logic [55:0]      es_q, es_d;
  logic [39:0]      harm_q, harm_d;
  logic [31:0]      median_q, median_d;

  // working registers
  logic             type_q, type_d;
  logic [31:0]      first_q, first_d;
  logic [31:0]      bytes_q, bytes_d;
  logic [31:0]      seg_q, seg_d;
  logic [31:0]      dt_q, dt_d;
  logic [39:0]      rate_q, rate_d;
  logic [59:0]      prod_q;
  logic [57:0]      acc_q, acc_d;
  logic [16:0]      mix_a_q, mix_a_d;
  logic [39:0]      mix_x_q, mix_x_d;
  logic [55:0]      mix_y_q, mix_y_d;
  mix_sel_e         mix_sel_q, mix_sel_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d;
  logic [31:0]      vi_q, vi_d, va_q, va_d, vb_q, vb_d;
  logic [CNT_W-1:0] less_q, less_d, eq_q, eq_d;
  logic [WIN_W-1:0] w_q, w_d, k_q, k_d;
  logic [63:0]      sum_q, sum_d;
  logic [CNT_W-1:0] hcnt_q, hcnt_d;
  logic [39:0]      thr_q, thr_d;
  logic [47:0]      pred_q, pred_d;
  logic [39:0]      othr_q, othr_d;
  logic [31:0]      omed_q, omed_d;
  logic [47:0]      opred_q, opred_d;
  logic [4:0]       ocnt_q, ocnt_d;

  // datapath helpers
  logic [19:0]      mul_a;
  logic [39:0]      mul_b;
  logic [16:0]      mix_b;
  logic [57:0]      mix_res;
  logic [39:0]      rate_sat;
  logic [39:0]      harm_sat;
  logic [63:0]      pred_sum;
  logic [31:0]      ttfb_rdata;
  logic [39:0]      rate_rdata;
  logic [IDX_W-1:0] ttfb_raddr, rate_raddr;
  logic             ring_we;
  logic [SB_W-1:0]  sb_raw;
  logic [CNT_W-1:0] k_hi, k_lo;
  logic [CNT_W:0]   span;
  logic             hit_a, hit_b;
  logic [WIN_W-1:0] win_cfg, win_cnt;
  logic [55:0]      ewma_pick;

  function automatic logic [16:0] clamp_q16(input logic [16:0] w);
    return (w > OneQ16) ? OneQ16 : w;
  endfunction

  dte_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dte_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  dte_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_ttfb_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (head_q),
    .wdata_i (first_q),
    .raddr_i (ttfb_raddr),
    .rdata_o (ttfb_rdata)
  );

  dte_ram #(.WIDTH(40), .DEPTH(HISTORY_DEPTH)) u_rate_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (head_q),
    .wdata_i (rate_sat),
    .raddr_i (rate_raddr),
    .rdata_o (rate_rdata)
  );

  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = ovalid_q;
  assign rsp_o.throughput_bps = othr_q;
  assign rsp_o.median_ttfb_us = omed_q;
  assign rsp_o.predicted_us   = opred_q;
  assign rsp_o.history_count  = ocnt_q;

  assign mix_b    = OneQ16 - mix_a_q;
  assign mix_res  = acc_q + 58'(prod_q[59:16]);
  assign rate_sat = (div_rsp.quotient > 64'(RateMax)) ? RateMax : div_rsp.quotient[39:0];
  assign harm_sat = rate_sat;
  assign pred_sum = 64'(median_q) + div_rsp.quotient;
  assign ring_we  = (state_q == S_RDW) && div_rsp.done;

  // k-th newest slot: head - k, wrapped
  always_comb begin
    sb_raw = SB_W'(head_q) + SB_W'(HISTORY_DEPTH) - SB_W'(k_q);
    if (sb_raw >= SB_W'(HISTORY_DEPTH)) begin
      sb_raw = sb_raw - SB_W'(HISTORY_DEPTH);
    end
  end
  assign rate_raddr = IDX_W'(sb_raw);

  always_comb begin
    case (state_q)
      S_MRD:   ttfb_raddr = i_q;
      S_MCAP:  ttfb_raddr = '0;
      default: ttfb_raddr = IDX_W'(j_q + 1'b1);
    endcase
  end

  // median ranks: odd count uses the middle twice
  assign k_hi  = cnt_q >> 1;
  assign k_lo  = cnt_q[0] ? k_hi : k_hi - 1'b1;
  assign span  = {1'b0, less_q} + {1'b0, eq_q};
  assign hit_a = (less_q <= k_lo) && ({1'b0, k_lo} < span);
  assign hit_b = (less_q <= k_hi) && ({1'b0, k_hi} < span);

  assign win_cfg   = WIN_W'(cfg.window_len);
  assign win_cnt   = WIN_W'(cnt_q);
  assign ewma_pick = (ef_q != '0 && es_q != '0) ? ((ef_q < es_q) ? ef_q : es_q)
                                                  : ((ef_q > es_q) ? ef_q : es_q);

  // shared multiplier operands
  always_comb begin
    case (state_q)
      S_RMUL: begin
        mul_a = UsecPerSec;
        mul_b = 40'(bytes_q);
      end
      S_PMUL: begin
        mul_a = UsecPerSec;
        mul_b = 40'(seg_q);
      end
      S_M1: begin
        mul_a = 20'(mix_a_q);
        mul_b = mix_x_q;
      end
      S_M2: begin
        mul_a = 20'(mix_b);
        mul_b = mix_y_q[55:16];
      end
      S_M3: begin
        mul_a = 20'(mix_b);
        mul_b = 40'(mix_y_q[15:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = 64'(prod_q);
    div_req.divisor  = 64'(dt_q);
    case (state_q)
      S_RDIV: div_req.start = 1'b1;
      S_HCHK: begin
        div_req.start    = (rate_rdata != '0);
        div_req.dividend = 64'd1 << 56;
        div_req.divisor  = 64'(rate_rdata);
      end
      S_HFIN: begin
        div_req.start    = (hcnt_q != '0);
        div_req.dividend = 64'(hcnt_q) << 56;
        div_req.divisor  = sum_q;
      end
      S_PDIV: begin
        div_req.start   = 1'b1;
        div_req.divisor = 64'(thr_q);
      end
      default: div_req.start = 1'b0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    ovalid_d  = ovalid_q;
    ef_d      = ef_q;
    es_d      = es_q;
    harm_d    = harm_q;
    median_d  = median_q;
    type_d    = type_q;
    first_d   = first_q;
    bytes_d   = bytes_q;
    seg_d     = seg_q;
    dt_d      = dt_q;
    rate_d    = rate_q;
    acc_d     = acc_q;
    mix_a_d   = mix_a_q;
    mix_x_d   = mix_x_q;
    mix_y_d   = mix_y_q;
    mix_sel_d = mix_sel_q;
    i_d       = i_q;
    j_d       = j_q;
    vi_d      = vi_q;
    va_d      = va_q;
    vb_d      = vb_q;
    less_d    = less_q;
    eq_d      = eq_q;
    w_d       = w_q;
    k_d       = k_q;
    sum_d     = sum_q;
    hcnt_d    = hcnt_q;
    thr_d     = thr_q;
    pred_d    = pred_q;
    othr_d    = othr_q;
    omed_d    = omed_q;
    opred_d   = opred_q;
    ocnt_d    = ocnt_q;

    if (ovalid_q && rsp_o.ready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          type_d  = req_i.req_type;
          first_d = req_i.first_byte_us;
          bytes_d = req_i.download_bytes;
          seg_d   = req_i.segment_bytes;
          dt_d    = (req_i.total_time_us > req_i.first_byte_us) ?
                    (req_i.total_time_us - req_i.first_byte_us) : 32'd1;
          state_d = req_i.req_type ? S_BSET : S_RMUL;
        end
      end
      S_RMUL: state_d = S_RDIV;
      S_RDIV: state_d = S_RDW;
      S_RDW: begin
        if (div_rsp.done) begin
          rate_d  = rate_sat;
          head_d  = (head_q == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
          if (cnt_q != CNT_W'(HISTORY_DEPTH)) begin
            cnt_d = cnt_q + 1'b1;
          end
          state_d = S_EF;
        end
      end
      S_EF: begin
        if (ef_q == '0) begin
          ef_d    = {rate_q, 16'd0};
          state_d = S_ES;
        end else begin
          mix_a_d   = clamp_q16(cfg.fast_weight);
          mix_x_d   = rate_q;
          mix_y_d   = ef_q;
          mix_sel_d = MIX_FAST;
          state_d   = S_M1;
        end
      end
      S_ES: begin
        if (es_q == '0) begin
          es_d    = {rate_q, 16'd0};
          state_d = S_MDI;
        end else begin
          mix_a_d   = clamp_q16(cfg.slow_weight);
          mix_x_d   = rate_q;
          mix_y_d   = es_q;
          mix_sel_d = MIX_SLOW;
          state_d   = S_M1;
        end
      end
      S_M1: state_d = S_M2;
      S_M2: begin
        acc_d   = 58'(prod_q);
        state_d = S_M3;
      end
      S_M3: begin
        acc_d   = acc_q + 58'(prod_q);
        state_d = S_M4;
      end
      S_M4: begin
        case (mix_sel_q)
          MIX_FAST: begin
            ef_d    = mix_res[55:0];
            state_d = S_ES;
          end
          MIX_SLOW: begin
            es_d    = mix_res[55:0];
            state_d = S_MDI;
          end
          default: begin
            thr_d   = mix_res[55:16];
            state_d = S_FIN;
          end
        endcase
      end
      S_MDI: begin
        if (cnt_q == '0) begin
          median_d = '0;
          state_d  = S_HINI;
        end else begin
          i_d     = '0;
          state_d = S_MRD;
        end
      end
      S_MRD: state_d = S_MCAP;
      S_MCAP: begin
        vi_d    = ttfb_rdata;
        j_d     = '0;
        less_d  = '0;
        eq_d    = '0;
        state_d = S_MSCAN;
      end
      S_MSCAN: begin
        less_d = less_q + CNT_W'(ttfb_rdata < vi_q);
        eq_d   = eq_q + CNT_W'(ttfb_rdata == vi_q);
        if (CNT_W'(j_q) == cnt_q - 1'b1) begin
          state_d = S_MEVAL;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_MEVAL: begin
        if (hit_a) begin
          va_d = vi_q;
        end
        if (hit_b) begin
          vb_d = vi_q;
        end
        if (CNT_W'(i_q) == cnt_q - 1'b1) begin
          state_d = S_MFIN;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_MRD;
        end
      end
      S_MFIN: begin
        median_d = 32'((33'(va_q) + 33'(vb_q)) >> 1);
        state_d  = S_HINI;
      end
      S_HINI: begin
        w_d    = (win_cfg < win_cnt) ? win_cfg : win_cnt;
        k_d    = WIN_W'(1);
        sum_d  = '0;
        hcnt_d = '0;
        if (w_d == '0) begin
          harm_d  = '0;
          state_d = S_BSET;
        end else begin
          state_d = S_HRD;
        end
      end
      S_HRD: state_d = S_HCHK;
      S_HCHK: state_d = (rate_rdata != '0) ? S_HDW : S_HNXT;
      S_HDW: begin
        if (div_rsp.done) begin
          sum_d   = sum_q + div_rsp.quotient;
          hcnt_d  = hcnt_q + 1'b1;
          state_d = S_HNXT;
        end
      end
      S_HNXT: begin
        if (k_q == w_q) begin
          state_d = S_HFIN;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_HRD;
        end
      end
      S_HFIN: begin
        if (hcnt_q == '0) begin
          harm_d  = '0;
          state_d = S_BSET;
        end else begin
          state_d = S_HFW;
        end
      end
      S_HFW: begin
        if (div_rsp.done) begin
          harm_d  = harm_sat;
          state_d = S_BSET;
        end
      end
      S_BSET: begin
        if (ewma_pick == '0) begin
          thr_d   = harm_q;
          state_d = S_FIN;
        end else if (harm_q == '0) begin
          thr_d   = ewma_pick[55:16];
          state_d = S_FIN;
        end else begin
          mix_a_d   = clamp_q16(cfg.blend_weight);
          mix_x_d   = harm_q;
          mix_y_d   = ewma_pick;
          mix_sel_d = MIX_BLEND;
          state_d   = S_M1;
        end
      end
      S_FIN: begin
        if (type_q && thr_q != '0) begin
          state_d = S_PMUL;
        end else begin
          pred_d  = '0;
          state_d = S_OUT;
        end
      end
      S_PMUL: state_d = S_PDIV;
      S_PDIV: state_d = S_PDW;
      S_PDW: begin
        if (div_rsp.done) begin
          pred_d  = (pred_sum > 64'(PredMax)) ? PredMax : pred_sum[47:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ovalid_q || rsp_o.ready) begin
          ovalid_d = 1'b1;
          othr_d   = thr_q;
          omed_d   = median_q;
          opred_d  = pred_q;
          ocnt_d   = 5'(cnt_q);
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      ef_q     <= '0;
      es_q     <= '0;
      harm_q   <= '0;
      median_q <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      ef_q     <= ef_d;
      es_q     <= es_d;
      harm_q   <= harm_d;
      median_q <= median_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q    <= type_d;
    first_q   <= first_d;
    bytes_q   <= bytes_d;
    seg_q     <= seg_d;
    dt_q      <= dt_d;
    rate_q    <= rate_d;
    prod_q    <= mul_a * mul_b;
    acc_q     <= acc_d;
    mix_a_q   <= mix_a_d;
    mix_x_q   <= mix_x_d;
    mix_y_q   <= mix_y_d;
    mix_sel_q <= mix_sel_d;
    i_q       <= i_d;
    j_q       <= j_d;
    vi_q      <= vi_d;
    va_q      <= va_d;
    vb_q      <= vb_d;
    less_q    <= less_d;
    eq_q      <= eq_d;
    w_q       <= w_d;
    k_q       <= k_d;
    sum_q     <= sum_d;
    hcnt_q    <= hcnt_d;
    thr_q     <= thr_d;
    pred_q    <= pred_d;
    othr_q    <= othr_d;
    omed_q    <= omed_d;
    opred_q   <= opred_d;
    ocnt_q    <= ocnt_d;
  end

endmodule

[src/dte_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dte_checker
// Port-level checks of the throughput estimator, bound to the top level.
// ----------------------------------------------------------------------------
module dte_checker
  import dte_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HistoryDepthDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [39:0] throughput_bps,
  input logic [31:0] median_ttfb_us,
  input logic [47:0] predicted_us,
  input logic [4:0]  history_count
);

  logic [1:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = req_valid && req_ready;
  assign out_acc = rsp_valid && rsp_ready;

  // words taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable({throughput_bps, median_ttfb_us, predicted_us, history_count}))
    else $error("result word changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> pend_q != 2'd0)
    else $error("result without a pending request");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two words in flight");

  a_pred_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && throughput_bps == 40'd0 |-> predicted_us == 48'd0)
    else $error("prediction without throughput estimate");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (HISTORY_DEPTH > 31) || (history_count <= 5'(HISTORY_DEPTH)))
    else $error("history count above depth");

endmodule

bind download_throughput_estimator dte_checker #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dte_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid      (req_i.valid),
  .req_ready      (req_i.ready),
  .rsp_valid      (rsp_o.valid),
  .rsp_ready      (rsp_o.ready),
  .throughput_bps (rsp_o.throughput_bps),
  .median_ttfb_us (rsp_o.median_ttfb_us),
  .predicted_us   (rsp_o.predicted_us),
  .history_count  (rsp_o.history_count)
);

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the throughput estimator against a cycle-free model of its math.
// Record and predict words are pushed through a valid/ready driver. Every
// accepted word is run through the model at once, and each result word is
// compared field by field in order. The registers are reprogrammed between
// phases while the block is idle. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module testbench;
  import dte_pkg::*;

  typedef struct {
    bit        req_type;
    bit [31:0] total_us;
    bit [31:0] first_us;
    bit [31:0] dl_bytes;
    bit [31:0] seg_bytes;
  } dl_word_t;

  typedef struct {
    bit [39:0] thr;
    bit [31:0] med;
    bit [47:0] pred;
    bit [4:0]  cnt;
  } est_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  dte_req_if req_if ();
  dte_rsp_if rsp_if ();

  download_throughput_estimator dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .req_i(req_if.sink), .rsp_o(rsp_if.source)
  );

  always #6 clk_i = ~clk_i;

  dl_word_t pending_words[$];
  est_t     expected_est[$];
  int       errors = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  // shadow of the estimator state
  bit [31:0] ttfb_hist[24];
  bit [39:0] rate_hist[24];
  int        hist_head = 0;
  int        hist_count = 0;
  bit [63:0] ewma_fast = 0;
  bit [63:0] ewma_slow = 0;
  bit [63:0] harm_rate = 0;
  bit [31:0] med_ttfb = 0;
  bit [16:0] fast_wt = AlphaFastRst;
  bit [16:0] slow_wt = AlphaSlowRst;
  bit [4:0]  window_len = WindowLenRst;
  bit [16:0] blend_weight = BlendWeightRst;

  function automatic void add_word(dl_word_t d);
    pending_words.insert(pending_words.size(), d);
  endfunction

  function automatic bit [63:0] sat_weight(bit [16:0] w);
    return (w > OneQ16) ? 64'(OneQ16) : 64'(w);
  endfunction

  function automatic bit [63:0] weighted_avg(bit [63:0] a, bit [63:0] x, bit [63:0] y);
    bit [63:0] b, hi, lo;
    b  = 64'd65536 - a;
    hi = a * (x >> 16) + b * (y >> 16);
    lo = a * (x & 64'hFFFF) + b * (y & 64'hFFFF);
    return hi + (lo >> 16);
  endfunction

  function automatic bit [63:0] ewma_next(bit [63:0] e, bit [16:0] a, bit [63:0] rq);
    if (e == 0) return rq;
    return weighted_avg(sat_weight(a), rq, e);
  endfunction

  function automatic bit [63:0] blended_rate();
    bit [63:0] m;
    if (ewma_fast != 0 && ewma_slow != 0) m = (ewma_fast < ewma_slow) ? ewma_fast : ewma_slow;
    else m = (ewma_fast > ewma_slow) ? ewma_fast : ewma_slow;
    if (m == 0) return harm_rate;
    if (harm_rate == 0) return m >> 16;
    return weighted_avg(sat_weight(blend_weight), harm_rate << 16, m) >> 16;
  endfunction

  function automatic void refresh_stats();
    bit [31:0] srt[24];
    bit [63:0] sum, r;
    int        w, cnt, slot, j;
    sum = 0;
    cnt = 0;
    for (int i = 0; i < hist_count; i++) begin
      j = i;
      while (j > 0 && srt[j - 1] > ttfb_hist[i]) begin
        srt[j] = srt[j - 1];
        j--;
      end
      srt[j] = ttfb_hist[i];
    end
    if (hist_count == 0) med_ttfb = 0;
    else if (hist_count % 2) med_ttfb = srt[hist_count / 2];
    else med_ttfb = 32'(({32'd0, srt[hist_count/2 - 1]} + srt[hist_count/2]) >> 1);
    w = (window_len < hist_count) ? window_len : hist_count;
    for (int k = 1; k <= w; k++) begin
      slot = (hist_head + 24 - (k % 24)) % 24;
      r = rate_hist[slot];
      if (r != 0) begin
        sum += (64'd1 << 56) / r;
        cnt++;
      end
    end
    if (cnt == 0 || sum == 0) harm_rate = 0;
    else begin
      harm_rate = (64'(cnt) << 56) / sum;
      if (harm_rate > RateMax) harm_rate = RateMax;
    end
  endfunction

  function automatic est_t estimate_step(dl_word_t d);
    est_t      e;
    bit [63:0] thr, pred, dt, rate;
    pred = 0;
    if (!d.req_type) begin
      dt = (d.total_us > d.first_us) ? 64'(d.total_us - d.first_us) : 64'd1;
      rate = (64'(d.dl_bytes) * 64'd1000000) / dt;
      if (rate > RateMax) rate = RateMax;
      ttfb_hist[hist_head] = d.first_us;
      rate_hist[hist_head] = rate[39:0];
      hist_head = (hist_head + 1) % 24;
      if (hist_count < 24) hist_count++;
      ewma_fast = ewma_next(ewma_fast, fast_wt, rate << 16);
      ewma_slow = ewma_next(ewma_slow, slow_wt, rate << 16);
      refresh_stats();
      thr = blended_rate();
    end else begin
      thr = blended_rate();
      if (thr != 0) begin
        pred = 64'(med_ttfb) + (64'(d.seg_bytes) * 64'd1000000) / thr;
        if (pred > PredMax) pred = PredMax;
      end
    end
    e.thr  = thr[39:0];
    e.med  = med_ttfb;
    e.pred = pred[47:0];
    e.cnt  = hist_count[4:0];
    return e;
  endfunction

  task automatic report(string what, bit [63:0] got, bit [63:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.req_type <= 1'b0;
      req_if.total_time_us <= '0;
      req_if.first_byte_us <= '0;
      req_if.download_bytes <= '0;
      req_if.segment_bytes <= '0;
    end else if (!req_if.valid || req_if.ready) begin
      if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        dl_word_t d;
        d = pending_words.pop_front();
        req_if.valid <= 1'b1;
        req_if.req_type <= d.req_type;
        req_if.total_time_us <= d.total_us;
        req_if.first_byte_us <= d.first_us;
        req_if.download_bytes <= d.dl_bytes;
        req_if.segment_bytes <= d.seg_bytes;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // accepted word -> expected result
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      dl_word_t d;
      d.req_type  = req_if.req_type;
      d.total_us  = req_if.total_time_us;
      d.first_us  = req_if.first_byte_us;
      d.dl_bytes  = req_if.download_bytes;
      d.seg_bytes = req_if.segment_bytes;
      expected_est.insert(expected_est.size(), estimate_step(d));
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_est.size() == 0) begin
          report("unexpected word", rsp_if.throughput_bps, 0);
        end else begin
          est_t e;
          e = expected_est.pop_front();
          if (rsp_if.throughput_bps !== e.thr)
            report("throughput_bps", rsp_if.throughput_bps, e.thr);
          if (rsp_if.median_ttfb_us !== e.med)
            report("median_ttfb_us", rsp_if.median_ttfb_us, e.med);
          if (rsp_if.predicted_us !== e.pred)
            report("predicted_us", rsp_if.predicted_us, e.pred);
          if (rsp_if.history_count !== e.cnt)
            report("history_count", rsp_if.history_count, e.cnt);
        end
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic reg_write(reg_idx_e idx, bit [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ApbAddrW'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ALPHA_FAST:   fast_wt = val[16:0];
      REG_ALPHA_SLOW:   slow_wt = val[16:0];
      REG_WINDOW_LEN:   window_len = val[4:0];
      REG_BLEND_WEIGHT: blend_weight = val[16:0];
      default: ;
    endcase
  endtask

  // sampled at the falling edge so every rising-edge update has settled
  task automatic wait_drained();
    while (pending_words.size() > 0 || expected_est.size() > 0 || req_if.valid)
      @(negedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic program_regs(bit [31:0] af, bit [31:0] as, bit [31:0] wl, bit [31:0] bw);
    reg_write(REG_ALPHA_FAST, af);
    reg_write(REG_ALPHA_SLOW, as);
    reg_write(REG_WINDOW_LEN, wl);
    reg_write(REG_BLEND_WEIGHT, bw);
  endtask

  function automatic dl_word_t record_word(bit [31:0] total, bit [31:0] first, bit [31:0] nb);
    dl_word_t d;
    d.req_type = 1'b0;
    d.total_us = total;
    d.first_us = first;
    d.dl_bytes = nb;
    d.seg_bytes = $urandom;
    return d;
  endfunction

  function automatic dl_word_t predict_word(bit [31:0] seg);
    dl_word_t d;
    d.req_type = 1'b1;
    d.total_us = $urandom;
    d.first_us = $urandom;
    d.dl_bytes = $urandom;
    d.seg_bytes = seg;
    return d;
  endfunction

  function automatic dl_word_t random_word();
    bit [31:0] f;
    if ($urandom_range(0, 99) < 40)
      return predict_word($urandom_range(0, 1) ? $urandom : $urandom_range(0, 10000000));
    f = $urandom;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: begin
        f = $urandom_range(0, 500000);
        return record_word(f + $urandom_range(1, 5000000), f, $urandom_range(0, 20000000));
      end
      4: return record_word($urandom, $urandom, $urandom);
      5: return record_word($urandom_range(0, f), f, $urandom);
      6: return record_word($urandom, $urandom, 32'd0);
      default: begin
        f = $urandom_range(0, 32'hFFFF_0000);
        return record_word(f + $urandom_range(1, 3), f, $urandom);
      end
    endcase
  endfunction

  task automatic run_phase(int n, int idle, int stall, bit pause_mid);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      add_word(random_word());
      // sender holds off until the block has fully caught up
      if (pause_mid && i == n / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty history, extremes, saturation, total below first byte
    add_word(predict_word(32'hFFFF_FFFF));
    add_word(record_word(32'd0, 32'd0, 32'd0));
    add_word(predict_word(32'd1000));
    add_word(record_word(32'd1000, 32'd2000, 32'd5000));
    add_word(record_word(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF));
    add_word(record_word(32'd1, 32'd0, 32'hFFFF_FFFF));
    add_word(predict_word(32'hFFFF_FFFF));
    add_word(record_word(32'd5, 32'hFFFF_FFFF, 32'd1));
    add_word(record_word(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd1));
    add_word(predict_word(32'd0));
    add_word(record_word(32'd200000, 32'd100000, 32'd1000000));
    add_word(predict_word(32'd2000000));
    wait_drained();
    // zero alphas with max blend, then weights above one
    program_regs(32'd0, 32'd0, 32'd24, 32'd65536);
    for (int i = 0; i < 6; i++)
      add_word(record_word(32'd3000 + i, 32'd1000 * i, 32'd70000 * (i + 1)));
    add_word(predict_word(32'hFFFF_FFFF));
    wait_drained();
    program_regs(32'h1FFFF, 32'd65536, 32'd0, 32'h1FFFF);
    add_word(record_word(32'd9000, 32'd100, 32'd12345));
    add_word(predict_word(32'd77777));
    wait_drained();

    program_regs(32'd65536, 32'd1, 32'd24, 32'd65536);
    run_phase(220, 0, 0, 1'b1);
    program_regs(32'd0, 32'h1FFFF, 32'd1, 32'd0);
    run_phase(220, 51, 0, 1'b0);
    program_regs($urandom_range(0, 65536), $urandom_range(0, 65536), 32'd0, 32'd100000);
    run_phase(220, 0, 51, 1'b0);
    program_regs($urandom_range(0, 131071), $urandom_range(0, 131071), 32'd31, 32'd39322);
    run_phase(220, 36, 36, 1'b0);
    program_regs(32'd32768, 32'd6554, $urandom_range(1, 24), $urandom_range(0, 65536));
    run_phase(220, 0, 0, 1'b0);

    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #400ms;
    $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
src/dte_pkg.sv
src/dte_if.sv
src/dte_ram.sv
src/dte_div.sv
src/dte_regs.sv
src/download_throughput_estimator.sv
src/dte_checker.sv
bench/testbench.sv
